FILE: sv/i128alu_pkg.sv
// Package for the 128-bit integer ALU: widths, opcodes, stage structs and
// the limb table of the multiplier. No dependencies.
`default_nettype none

package i128alu_pkg;

  localparam int unsigned WIDTH    = 128;
  localparam int unsigned HI_BITS  = WIDTH - 64;
  localparam int unsigned CNT_BITS = $clog2(WIDTH);
  localparam int unsigned PP_N     = 10;

  typedef logic [WIDTH-1:0] word_t;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_AND  = 4'd4,
    OP_OR   = 4'd5,
    OP_XOR  = 4'd6,
    OP_NOT  = 4'd7,
    OP_SHL  = 4'd8,
    OP_SAR  = 4'd9,
    OP_ROL1 = 4'd10,
    OP_ROR1 = 4'd11,
    OP_NE   = 4'd12
  } op_t;

  typedef struct packed {
    logic  valid;
    op_t   op;
    word_t res;
    logic  ne;
    logic  dz;
    logic  qneg;
  } side_t;

  typedef struct packed {
    side_t                  side;
    logic [PP_N-1:0][63:0]  pp;
    word_t                  num;
    word_t                  den;
  } front_t;

  // 32-bit limb of a used by partial product k (only products below column 4)
  function automatic int unsigned pp_ai(int unsigned k);
    int unsigned r;
    r = 0;
    if (k >= 4) r = 1;
    if (k >= 7) r = 2;
    if (k >= 9) r = 3;
    return r;
  endfunction

  // 32-bit limb of b used by partial product k
  function automatic int unsigned pp_bj(int unsigned k);
    int unsigned r;
    r = k;
    if (k >= 4) r = k - 4;
    if (k >= 7) r = k - 7;
    if (k >= 9) r = k - 9;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/int128_alu.sv
// Path of an item: input register, front stage, s2, s3, delay line dl, then
// the output register; dl keeps it in step with the one-bit-per-stage divider.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline.
// Reset: rst (synchronous) clears all valid bits; data registers are not reset.
// Top level of the 128-bit ALU; uses i128alu_pkg, i128alu_front, i128alu_div.
`default_nettype none

module int128_alu
  import i128alu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  op,
  input  wire logic [63:0] a_hi,
  input  wire logic [63:0] a_lo,
  input  wire logic [63:0] b_hi,
  input  wire logic [63:0] b_lo,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      res_hi,
  output logic [63:0]      res_lo,
  output logic             not_equal,
  output logic             div_zero
);

  logic   en;
  logic   iv;
  op_t    iop;
  word_t  ia;
  word_t  ib;
  front_t fq;
  word_t  quo;
  side_t  s2;
  word_t  sum0;
  word_t  sum1;
  side_t  s3;
  side_t  s3_next;
  side_t  dl [WIDTH-2];
  word_t  sum0_next;
  word_t  sum1_next;
  word_t  qs;
  word_t  res;

  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (en) begin
      iv  <= in_valid;
      iop <= op_t'(op);
      ia  <= {a_hi[HI_BITS-1:0], a_lo};
      ib  <= {b_hi[HI_BITS-1:0], b_lo};
    end
  end

  i128alu_front u_front (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .valid (iv),
    .op    (iop),
    .a     (ia),
    .b     (ib),
    .q     (fq)
  );

  i128alu_div u_div (
    .clk (clk),
    .en  (en),
    .num (fq.num),
    .den (fq.den),
    .quo (quo)
  );

  // product: two half sums, then the final add
  always_comb begin
    sum0_next = '0;
    sum1_next = '0;
    for (int unsigned k = 0; k < PP_N; k++) begin
      if (k < 5) begin
        sum0_next = sum0_next + word_t'(128'(fq.pp[k]) << (32 * (pp_ai(k) + pp_bj(k))));
      end else begin
        sum1_next = sum1_next + word_t'(128'(fq.pp[k]) << (32 * (pp_ai(k) + pp_bj(k))));
      end
    end
  end

  always_comb begin
    s3_next = s2;
    if (s2.op == OP_MUL) begin
      s3_next.res = sum0 + sum1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
      for (int i = 0; i < WIDTH - 2; i++) begin
        dl[i].valid <= 1'b0;
      end
    end else if (en) begin
      s2   <= fq.side;
      sum0 <= sum0_next;
      sum1 <= sum1_next;
      s3   <= s3_next;
      dl[0] <= s3;
      for (int i = 1; i < WIDTH - 2; i++) begin
        dl[i] <= dl[i-1];
      end
    end
  end

  always_comb begin
    qs  = dl[WIDTH-3].qneg ? word_t'(-quo) : quo;
    res = dl[WIDTH-3].res;
    if (dl[WIDTH-3].op == OP_DIV && !dl[WIDTH-3].dz) begin
      res = qs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dl[WIDTH-3].valid;
      res_hi    <= 64'(res[WIDTH-1:64]);
      res_lo    <= res[63:0];
      not_equal <= dl[WIDTH-3].ne;
      div_zero  <= dl[WIDTH-3].dz;
    end
  end

  a_dz_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && div_zero |-> res_hi == '0 && res_lo == '0)
    else $error("divide by zero with nonzero result");

  a_ne_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && not_equal |-> res_hi == '0 && res_lo == '0)
    else $error("compare with nonzero result");

  a_flags : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(div_zero && not_equal))
    else $error("both flags set");

endmodule

`default_nettype wire

FILE: sv/i128alu_front.sv
// Operand stage: simple ops, shifts, flags, multiplier partial products and
// divider operand magnitudes, all registered. Uses i128alu_pkg.
`default_nettype none

module i128alu_front
  import i128alu_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   en,
  input  wire logic   valid,
  input  wire op_t    op,
  input  wire word_t  a,
  input  wire word_t  b,
  output front_t      q
);

  front_t       q_next;
  logic [127:0] a128;
  logic [127:0] b128;
  logic         big;
  logic [CNT_BITS-1:0] cnt;
  logic         na;
  logic         nb;

  always_comb begin
    a128 = 128'(a);
    b128 = 128'(b);
    big  = (b >= word_t'(WIDTH));
    cnt  = b[CNT_BITS-1:0];
    na   = a[WIDTH-1];
    nb   = b[WIDTH-1];

    q_next            = '0;
    q_next.side.valid = valid;
    q_next.side.op    = op;
    q_next.num        = na ? word_t'(-a) : a;
    q_next.den        = nb ? word_t'(-b) : b;
    q_next.side.qneg  = na ^ nb;

    for (int unsigned k = 0; k < PP_N; k++) begin
      q_next.pp[k] = 64'(a128[32*pp_ai(k) +: 32]) * 64'(b128[32*pp_bj(k) +: 32]);
    end

    unique case (op)
      OP_ADD:  q_next.side.res = a + b;
      OP_SUB:  q_next.side.res = a - b;
      OP_MUL:  q_next.side.res = '0;
      OP_DIV:  begin
        q_next.side.res = '0;
        q_next.side.dz  = (b == '0);
      end
      OP_AND:  q_next.side.res = a & b;
      OP_OR:   q_next.side.res = a | b;
      OP_XOR:  q_next.side.res = a ^ b;
      OP_NOT:  q_next.side.res = ~a;
      OP_SHL:  q_next.side.res = big ? '0 : (a << cnt);
      OP_SAR:  q_next.side.res = big ? {WIDTH{na}} : word_t'($signed(a) >>> cnt);
      OP_ROL1: q_next.side.res = {a[WIDTH-2:0], a[WIDTH-1]};
      OP_ROR1: q_next.side.res = {a[0], a[WIDTH-1:1]};
      OP_NE:   q_next.side.ne  = (a != b);
      default: q_next.side.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.side.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/i128alu_div.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Uses i128alu_pkg.
`default_nettype none

module i128alu_div
  import i128alu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  en,
  input  wire word_t num,
  input  wire word_t den,
  output word_t      quo
);

  word_t rem [WIDTH-1];
  word_t dv  [WIDTH-1];
  word_t nq  [WIDTH];

  for (genvar s = 0; s < WIDTH; s++) begin : g_stage
    word_t          rin;
    word_t          nin;
    word_t          din;
    word_t          rsh;
    logic [WIDTH:0] diff;

    if (s == 0) begin : g_first
      assign rin = '0;
      assign nin = num;
      assign din = den;
    end else begin : g_rest
      assign rin = rem[s-1];
      assign nin = nq[s-1];
      assign din = dv[s-1];
    end

    assign rsh  = {rin[WIDTH-2:0], nin[WIDTH-1]};
    assign diff = {1'b0, rsh} - {1'b0, din};

    always_ff @(posedge clk) begin
      if (en) begin
        nq[s] <= {nin[WIDTH-2:0], ~diff[WIDTH]};
      end
    end

    if (s < WIDTH - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s] <= diff[WIDTH] ? rsh : diff[WIDTH-1:0];
          dv[s]  <= din;
        end
      end
    end
  end

  assign quo = nq[WIDTH-1];

endmodule

`default_nettype wire

FILE: tb/int128_alu_tb.sv
// Self-checking testbench for the 128-bit integer ALU (int128_alu).
// Depends on i128alu_pkg for widths and opcodes; a scoreboard class predicts
// each item and checks results in order; a task and a receiver drive I/O.
`timescale 1ns / 100ps

module int128_alu_tb
  import i128alu_pkg::*;
;

  localparam logic [3:0] OP_SPARE_FIRST = 4'd13;
  localparam logic [3:0] OP_SPARE_LAST  = 4'd15;
  localparam int         RAND_ITEMS     = 450;
  localparam int         STALL_LIMIT    = 5000;
  localparam int         HOLD_CYCLES    = 400;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        ne;
    logic        dz;
  } alu_res_t;

  class alu_scoreboard;
    alu_res_t expected_q[$];
    int       errors;
    int       checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    function alu_res_t compute(logic [3:0] opc, word_t a, word_t b);
      alu_res_t r;
      word_t    w, ua, ub, q;
      logic     big;
      big = (b >= word_t'(WIDTH));
      w   = '0;
      r   = '0;
      case (opc)
        OP_ADD:  w = a + b;
        OP_SUB:  w = a - b;
        OP_MUL:  w = a * b;
        OP_DIV: begin
          if (b == '0) begin
            r.dz = 1'b1;
          end else begin
            ua = a[WIDTH-1] ? -a : a;
            ub = b[WIDTH-1] ? -b : b;
            q  = ua / ub;
            w  = (a[WIDTH-1] != b[WIDTH-1]) ? -q : q;
          end
        end
        OP_AND:  w = a & b;
        OP_OR:   w = a | b;
        OP_XOR:  w = a ^ b;
        OP_NOT:  w = ~a;
        OP_SHL:  w = big ? '0 : a << b[CNT_BITS-1:0];
        OP_SAR:  w = big ? {WIDTH{a[WIDTH-1]}} : word_t'($signed(a) >>> b[CNT_BITS-1:0]);
        OP_ROL1: w = {a[WIDTH-2:0], a[WIDTH-1]};
        OP_ROR1: w = {a[0], a[WIDTH-1:1]};
        OP_NE:   r.ne = (a != b);
        default: w = '0;
      endcase
      r.hi = w[WIDTH-1:64];
      r.lo = w[63:0];
      return r;
    endfunction

    function void note_input(logic [3:0] opc, word_t a, word_t b);
      expected_q.push_back(compute(opc, a, b));
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %0s: got %h want %h (result %0d)", what, got, want, checked);
      errors++;
    endtask

    task check_result(logic [63:0] hi, logic [63:0] lo, logic ne, logic dz);
      alu_res_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result", hi, 64'd0);
        return;
      end
      e = expected_q.pop_front();
      if (hi !== e.hi) report("res_hi", hi, e.hi);
      if (lo !== e.lo) report("res_lo", lo, e.lo);
      if (ne !== e.ne) report("not_equal", 64'(ne), 64'(e.ne));
      if (dz !== e.dz) report("div_zero", 64'(dz), 64'(e.dz));
      checked++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  op = '0;
  logic [63:0] a_hi = '0, a_lo = '0, b_hi = '0, b_lo = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] res_hi, res_lo;
  logic        not_equal, div_zero;

  alu_scoreboard sb = new();
  int  sent = 0;
  int  idle_cnt = 0;
  bit  quiet = 1'b0;

  always #1 clk = ~clk;

  int128_alu dut (
    .clk, .rst, .in_valid, .in_stall, .op, .a_hi, .a_lo, .b_hi, .b_lo,
    .out_valid, .out_stall, .res_hi, .res_lo, .not_equal, .div_zero
  );

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic word_t rand_operand();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return {1'b1, {(WIDTH-1){1'b0}}};
      3: return word_t'($urandom_range(20));
      4: return -word_t'($urandom_range(20));
      5: return {64'd0, rand64()};
      6: return {{64{1'b1}}, rand64()};
      default: return {rand64(), rand64()};
    endcase
  endfunction

  task send_item(logic [3:0] opc, word_t a, word_t b);
    while (!quiet && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op   <= opc;
    a_hi <= a[WIDTH-1:64];
    a_lo <= a[63:0];
    b_hi <= b[WIDTH-1:64];
    b_lo <= b[63:0];
    do @(posedge clk); while (in_stall);
    sb.note_input(opc, a, b);
    sent++;
  endtask

  task send_random();
    logic [3:0] opc;
    word_t      a, b;
    opc = 4'($urandom_range(15));
    a   = rand_operand();
    b   = rand_operand();
    if ((opc == OP_SHL || opc == OP_SAR) && $urandom_range(3) != 0)
      b = word_t'($urandom_range(WIDTH + 2));
    if (opc == OP_DIV && $urandom_range(5) == 0) b = '0;
    if (opc == OP_NE && $urandom_range(1) == 0) b = a;
    send_item(opc, a, b);
  endtask

  // receiver: random stalls, one long hold-off after the 150th accepted result
  initial begin
    int accepted;
    accepted = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall && !rst) begin
        sb.check_result(res_hi, res_lo, not_equal, div_zero);
        accepted++;
        if (accepted == 150) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
      end
      out_stall <= (!quiet && $urandom_range(99) < 33);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    word_t min_neg;
    min_neg = {1'b1, {(WIDTH-1){1'b0}}};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(OP_ADD, '1, word_t'(1));
    send_item(OP_ADD, {rand64(), rand64()}, {rand64(), rand64()});
    send_item(OP_SUB, '0, word_t'(1));
    send_item(OP_MUL, '1, '1);
    send_item(OP_MUL, {64'd0, 64'hffff_ffff_ffff_ffff}, {64'd0, 64'hffff_ffff_ffff_ffff});
    send_item(OP_DIV, word_t'(100), '0);
    send_item(OP_DIV, min_neg, '1);
    send_item(OP_DIV, -word_t'(7), word_t'(2));
    send_item(OP_DIV, word_t'(7), -word_t'(2));
    send_item(OP_DIV, -word_t'(7), -word_t'(2));
    send_item(OP_AND, '1, {rand64(), rand64()});
    send_item(OP_OR, '0, {rand64(), rand64()});
    send_item(OP_XOR, '1, '1);
    send_item(OP_NOT, '0, '0);
    send_item(OP_SHL, '1, word_t'(WIDTH - 1));
    send_item(OP_SHL, '1, word_t'(WIDTH));
    send_item(OP_SAR, min_neg, word_t'(WIDTH - 1));
    send_item(OP_SAR, min_neg, {64'd1, 64'd0});
    send_item(OP_SAR, {1'b0, {(WIDTH-1){1'b1}}}, word_t'(WIDTH));
    send_item(OP_ROL1, min_neg, '0);
    send_item(OP_ROR1, word_t'(1), '0);
    send_item(OP_NE, '1, '1);
    send_item(OP_NE, '1, {{(WIDTH-1){1'b1}}, 1'b0});
    send_item(OP_SPARE_FIRST, '1, '1);
    send_item(OP_SPARE_LAST, '1, '1);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      quiet = (i >= 250 && i < 330);
      send_random();
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d items: all opcodes, shift saturation, divide corner cases,", sent);
    $display("random stalls on both sides and one long output hold-off");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
